[rtl/cau_pkg.sv]
// Shared types, constants and helper functions for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

    // Fixed-point format and limits
    localparam int FRAC_BITS = 16;
    localparam int MAX_EXP   = 16;
    localparam int DATA_W    = 32;
    localparam int ECNT_W    = $clog2(MAX_EXP + 1);
    localparam int ACC_W     = 65;
    localparam int MAG_W     = 64;
    localparam int QUO_W     = 32;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int IN_W      = 144;
    localparam int OUT_W     = 72;

    // Opcodes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_MAG = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDSUB,
        S_PROD,
        S_ACC,
        S_DRE_GO,
        S_DRE_WAIT,
        S_DIM_GO,
        S_DIM_WAIT,
        S_SQ_GO,
        S_SQ_WAIT,
        S_STEP_END,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {K_CMUL, K_CDIV, K_MAG} kind_t;
    typedef enum logic [1:0] {SEL_XR, SEL_XI, SEL_BR, SEL_BI} opsel_t;
    typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} accop_t;
    typedef enum logic [2:0] {STO_NONE, STO_RE, STO_IM, STO_DEN, STO_NRE, STO_NIM} store_t;

    // One step of a product sequence
    typedef struct packed {
        opsel_t a;
        opsel_t b;
        accop_t acc;
        store_t sto;
        logic   last;
    } pstep_t;

    // Request to the divide / square-root unit
    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } ds_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } satv_t;

    // Clamp a sign/magnitude value to signed 32 bits
    function automatic satv_t sat32(input logic neg, input logic [MAG_W-1:0] mag);
        satv_t            r;
        logic [MAG_W-1:0] nmag;
        nmag = ~mag + MAG_W'(1);
        r.sat = 1'b0;
        if (neg) begin
            if (mag > MAG_W'(64'h8000_0000)) begin
                r.val = 32'h8000_0000;
                r.sat = 1'b1;
            end else begin
                r.val = nmag[DATA_W-1:0];
            end
        end else begin
            if (mag > MAG_W'(64'h7FFF_FFFF)) begin
                r.val = 32'h7FFF_FFFF;
                r.sat = 1'b1;
            end else begin
                r.val = mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

    // Magnitude of a signed accumulator value (|v| <= 2^63)
    function automatic logic [MAG_W-1:0] mag65(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] n;
        n = -v;
        return v[ACC_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    // Product sequences: complex multiply, complex divide setup, magnitude
    function automatic pstep_t prog_step(input kind_t k, input logic [2:0] idx);
        pstep_t s;
        s = '{a: SEL_XR, b: SEL_BR, acc: ACC_LOAD, sto: STO_NONE, last: 1'b0};
        case (k)
            K_CMUL: begin
                case (idx)
                    3'd0: s = '{SEL_XR, SEL_BR, ACC_LOAD, STO_NONE, 1'b0};
                    3'd1: s = '{SEL_XI, SEL_BI, ACC_SUB,  STO_RE,   1'b0};
                    3'd2: s = '{SEL_XI, SEL_BR, ACC_LOAD, STO_NONE, 1'b0};
                    default: s = '{SEL_XR, SEL_BI, ACC_ADD, STO_IM, 1'b1};
                endcase
            end
            K_CDIV: begin
                case (idx)
                    3'd0: s = '{SEL_BR, SEL_BR, ACC_LOAD, STO_NONE, 1'b0};
                    3'd1: s = '{SEL_BI, SEL_BI, ACC_ADD,  STO_DEN,  1'b0};
                    3'd2: s = '{SEL_XR, SEL_BR, ACC_LOAD, STO_NONE, 1'b0};
                    3'd3: s = '{SEL_XI, SEL_BI, ACC_ADD,  STO_NRE,  1'b0};
                    3'd4: s = '{SEL_XI, SEL_BR, ACC_LOAD, STO_NONE, 1'b0};
                    default: s = '{SEL_XR, SEL_BI, ACC_SUB, STO_NIM, 1'b1};
                endcase
            end
            default: begin
                case (idx)
                    3'd0: s = '{SEL_XR, SEL_XR, ACC_LOAD, STO_NONE, 1'b0};
                    default: s = '{SEL_XI, SEL_XI, ACC_ADD, STO_NRE, 1'b1};
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

[rtl/cau_divsqrt.sv]
// Iterative unit: fractional divide or integer square root, one bit per cycle.
`timescale 1ns / 1ps

module cau_divsqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cau_pkg::ds_req_t          req,
    input  logic [cau_pkg::MAG_W-1:0] num,   // sampled on start
    input  logic [cau_pkg::MAG_W-1:0] den,   // held stable by the caller
    output logic                      done,
    output logic [cau_pkg::MAG_W-1:0] mag
);
    import cau_pkg::*;

    localparam int SH_W = MAG_W + QUO_W;
    localparam logic [MAG_W-1:0] SQ_BIT0 = MAG_W'(1) << (MAG_W - 2);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                sqrt_reg, sqrt_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MAG_W-1:0]    rem_reg, rem_next;
    logic [MAG_W-1:0]    q_reg, q_next;
    logic [MAG_W-1:0]    bit_reg, bit_next;
    logic [QUO_W-1:0]    low_reg, low_next;

    logic [SH_W-1:0]     nsh;
    logic                big;
    logic [MAG_W:0]      x, y, diff;
    logic                ge;

    // Shared compare / subtract
    always_comb
    begin
        if (sqrt_reg)
        begin
            x = {1'b0, rem_reg};
            y = {1'b0, q_reg + bit_reg};
        end
        else
        begin
            x = {rem_reg, low_reg[QUO_W-1]};
            y = {1'b0, den};
        end
        ge   = (x >= y);
        diff = x - y;
    end

    // Start values for a divide; quotient of 2^32 or more saturates anyway
    assign nsh = {{QUO_W{1'b0}}, num} << FRAC_BITS;
    assign big = (nsh >= {den, {QUO_W{1'b0}}});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        bit_next  = bit_reg;
        low_next  = low_reg;
        if (req.start)
        begin
            sqrt_next = req.sqrt_mode;
            cnt_next  = CNT_W'(QUO_W - 1);
            q_next    = '0;
            if (req.sqrt_mode)
            begin
                rem_next  = num;
                bit_next  = SQ_BIT0;
                busy_next = 1'b1;
            end
            else if (big)
            begin
                q_next    = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = nsh[SH_W-1:QUO_W];
                low_next  = nsh[QUO_W-1:0];
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (sqrt_reg)
            begin
                if (ge)
                begin
                    rem_next = diff[MAG_W-1:0];
                    q_next   = (q_reg >> 1) + bit_reg;
                end
                else
                begin
                    q_next = q_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                rem_next = ge ? diff[MAG_W-1:0] : x[MAG_W-1:0];
                q_next   = {q_reg[MAG_W-2:0], ge};
                low_next = {low_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        bit_reg  <= bit_next;
        low_reg  <= low_next;
    end

    assign done = done_reg;
    assign mag  = q_reg;

    // Checks
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divsqrt started while busy");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == '0) |=> (done_reg && !busy_reg))
        else $error("divsqrt run did not finish");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divsqrt done while busy");

endmodule

[rtl/complex_arith_unit.sv]
// Top level: complex add, subtract, multiply, divide, power and magnitude.
// Multiply runs four products; divide runs six products and two divider waits; magnitude runs
// two products and a 32-step square root; add/sub needs no product. Power repeats a multiply
// step, or a divide step for a negative exponent, |exponent| times, at most 16.
// s_tready is low while an item is worked on, so a new item enters only once the last is done;
// the output register takes the result, so the next item enters while it waits. Async reset, control only.
`timescale 1ns / 1ps

module complex_arith_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // opcode, a_re, a_im, b_re, b_im, exponent (low bit up), zero pad
    input  logic [cau_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // result_re, result_im, status (low bit up), zero pad
    output logic [cau_pkg::OUT_W-1:0] m_tdata
);
    import cau_pkg::*;

    // Input fields
    logic [2:0]               in_op;
    logic signed [DATA_W-1:0] in_ar, in_ai, in_br, in_bi;
    logic [5:0]               in_exp;
    logic [6:0]               e_ext, e_abs;
    logic [ECNT_W-1:0]        e_cnt;

    assign in_op  = s_tdata[2:0];
    assign in_ar  = s_tdata[34:3];
    assign in_ai  = s_tdata[66:35];
    assign in_br  = s_tdata[98:67];
    assign in_bi  = s_tdata[130:99];
    assign in_exp = s_tdata[136:131];

    // Exponent magnitude, clamped
    assign e_ext = {in_exp[5], in_exp};
    assign e_abs = in_exp[5] ? (~e_ext + 7'd1) : e_ext;
    assign e_cnt = (e_abs > 7'(MAX_EXP)) ? ECNT_W'(MAX_EXP) : ECNT_W'(e_abs);

    state_t                   state_reg, state_next;
    logic [2:0]               op_reg, op_next;
    kind_t                    kind_reg, kind_next;
    logic signed [DATA_W-1:0] xr_reg, xr_next, xi_reg, xi_next;
    logic signed [DATA_W-1:0] br_reg, br_next, bi_reg, bi_next;
    logic [ECNT_W-1:0]        ecnt_reg, ecnt_next;
    logic [2:0]               pidx_reg, pidx_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [MAG_W-1:0]  prod_reg;
    logic [MAG_W-1:0]         den_reg, den_next;
    logic                     nre_neg_reg, nre_neg_next, nim_neg_reg, nim_neg_next;
    logic [MAG_W-1:0]         nre_mag_reg, nre_mag_next, nim_mag_reg, nim_mag_next;
    logic [DATA_W-1:0]        rr_reg, rr_next, ri_reg, ri_next;
    logic                     sat_reg, sat_next, dz_reg, dz_next;
    logic [DATA_W-1:0]        ore_reg, ore_next, oim_reg, oim_next;
    logic [1:0]               ost_reg, ost_next;
    logic                     mv_reg, mv_next;

    logic                     s_xfer, out_free;
    pstep_t                   step;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0]  p65, acc_new;
    logic [MAG_W-1:0]         acc_mag;
    logic signed [DATA_W:0]   sum33;
    logic signed [ACC_W-1:0]  sum65;
    satv_t                    sv_add_re, sv_add_im, sv_acc, sv_ds;
    ds_req_t                  ds_req;
    logic [MAG_W-1:0]         ds_num, ds_mag;
    logic                     ds_done;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign step     = prog_step(kind_reg, pidx_reg);

    // Shared multiplier operand select
    function automatic logic signed [DATA_W-1:0] pick(input opsel_t s,
        input logic signed [DATA_W-1:0] r0, input logic signed [DATA_W-1:0] r1,
        input logic signed [DATA_W-1:0] r2, input logic signed [DATA_W-1:0] r3);
        case (s)
            SEL_XR:  return r0;
            SEL_XI:  return r1;
            SEL_BR:  return r2;
            default: return r3;
        endcase
    endfunction

    assign mul_a = pick(step.a, xr_reg, xi_reg, br_reg, bi_reg);
    assign mul_b = pick(step.b, xr_reg, xi_reg, br_reg, bi_reg);

    // Accumulate
    assign p65     = {prod_reg[MAG_W-1], prod_reg};
    assign acc_new = (step.acc == ACC_LOAD) ? p65 :
                     (step.acc == ACC_ADD)  ? acc_reg + p65 : acc_reg - p65;
    assign acc_mag = mag65(acc_new);
    assign sv_acc  = sat32(acc_new[ACC_W-1], acc_mag >> FRAC_BITS);

    // Add / subtract of real parts and imaginary parts
    always_comb
    begin
        logic signed [DATA_W:0] sr, si;
        if (op_reg == OP_SUB)
        begin
            sr = {xr_reg[DATA_W-1], xr_reg} - {br_reg[DATA_W-1], br_reg};
            si = {xi_reg[DATA_W-1], xi_reg} - {bi_reg[DATA_W-1], bi_reg};
        end
        else
        begin
            sr = {xr_reg[DATA_W-1], xr_reg} + {br_reg[DATA_W-1], br_reg};
            si = {xi_reg[DATA_W-1], xi_reg} + {bi_reg[DATA_W-1], bi_reg};
        end
        sum33     = si;
        sum65     = ACC_W'(sr);
        sv_add_re = sat32(sum65[ACC_W-1], mag65(sum65));
        sv_add_im = sat32(sum33[DATA_W], mag65(ACC_W'(sum33)));
    end

    // Divider / square root hookup
    assign ds_req.start     = (state_reg == S_DRE_GO) || (state_reg == S_DIM_GO) ||
                              (state_reg == S_SQ_GO);
    assign ds_req.sqrt_mode = (state_reg == S_SQ_GO);
    assign ds_num = (state_reg == S_DIM_GO) ? nim_mag_reg : nre_mag_reg;
    assign sv_ds  = sat32((state_reg == S_DIM_WAIT) ? nim_neg_reg :
                          (state_reg == S_DRE_WAIT) ? nre_neg_reg : 1'b0, ds_mag);

    cau_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .num   (ds_num),
        .den   (den_reg),
        .done  (ds_done),
        .mag   (ds_mag)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    case (in_op)
                        OP_ADD, OP_SUB: state_next = S_ADDSUB;
                        OP_MUL, OP_MAG: state_next = S_PROD;
                        OP_DIV:
                            state_next = (in_br == '0 && in_bi == '0) ? S_FIN : S_PROD;
                        OP_POW:
                            state_next = ((in_ar == '0 && in_ai == '0) || e_cnt == '0) ?
                                         S_FIN : S_PROD;
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_ADDSUB:   state_next = S_FIN;
            S_PROD:     state_next = S_ACC;
            S_ACC:
            begin
                if (!step.last)
                    state_next = S_PROD;
                else if (kind_reg == K_CMUL)
                    state_next = S_STEP_END;
                else if (kind_reg == K_CDIV)
                    state_next = S_DRE_GO;
                else
                    state_next = S_SQ_GO;
            end
            S_DRE_GO:   state_next = S_DRE_WAIT;
            S_DRE_WAIT: state_next = ds_done ? S_DIM_GO : S_DRE_WAIT;
            S_DIM_GO:   state_next = S_DIM_WAIT;
            S_DIM_WAIT: state_next = ds_done ? S_STEP_END : S_DIM_WAIT;
            S_SQ_GO:    state_next = S_SQ_WAIT;
            S_SQ_WAIT:  state_next = ds_done ? S_FIN : S_SQ_WAIT;
            S_STEP_END:
                state_next = (op_reg == OP_POW && ecnt_reg != ECNT_W'(1)) ? S_PROD : S_FIN;
            S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next      = op_reg;
        kind_next    = kind_reg;
        xr_next      = xr_reg;
        xi_next      = xi_reg;
        br_next      = br_reg;
        bi_next      = bi_reg;
        ecnt_next    = ecnt_reg;
        pidx_next    = pidx_reg;
        acc_next     = acc_reg;
        den_next     = den_reg;
        nre_neg_next = nre_neg_reg;
        nre_mag_next = nre_mag_reg;
        nim_neg_next = nim_neg_reg;
        nim_mag_next = nim_mag_reg;
        rr_next      = rr_reg;
        ri_next      = ri_reg;
        sat_next     = sat_reg;
        dz_next      = dz_reg;
        ore_next     = ore_reg;
        oim_next     = oim_reg;
        ost_next     = ost_reg;
        mv_next      = mv_reg && !m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    op_next   = in_op;
                    xr_next   = in_ar;
                    xi_next   = in_ai;
                    br_next   = in_br;
                    bi_next   = in_bi;
                    ecnt_next = e_cnt;
                    pidx_next = '0;
                    sat_next  = 1'b0;
                    dz_next   = 1'b0;
                    rr_next   = '0;
                    ri_next   = '0;
                    kind_next = K_CMUL;
                    case (in_op)
                        OP_DIV:
                        begin
                            kind_next = K_CDIV;
                            dz_next   = (in_br == '0 && in_bi == '0);
                        end
                        OP_POW:
                        begin
                            kind_next = in_exp[5] ? K_CDIV : K_CMUL;
                            xr_next   = ONE_Q;
                            xi_next   = '0;
                            br_next   = in_ar;
                            bi_next   = in_ai;
                            if (!(in_ar == '0 && in_ai == '0) && e_cnt == '0)
                                rr_next = ONE_Q;
                        end
                        OP_MAG: kind_next = K_MAG;
                        default: kind_next = K_CMUL;
                    endcase
                end
            end
            S_ADDSUB:
            begin
                rr_next  = sv_add_re.val;
                ri_next  = sv_add_im.val;
                sat_next = sv_add_re.sat || sv_add_im.sat;
            end
            S_ACC:
            begin
                acc_next  = acc_new;
                pidx_next = step.last ? 3'd0 : pidx_reg + 3'd1;
                case (step.sto)
                    STO_RE:
                    begin
                        rr_next  = sv_acc.val;
                        sat_next = sat_reg || sv_acc.sat;
                    end
                    STO_IM:
                    begin
                        ri_next  = sv_acc.val;
                        sat_next = sat_reg || sv_acc.sat;
                    end
                    STO_DEN: den_next = acc_new[MAG_W-1:0];
                    STO_NRE:
                    begin
                        nre_neg_next = acc_new[ACC_W-1];
                        nre_mag_next = acc_mag;
                    end
                    STO_NIM:
                    begin
                        nim_neg_next = acc_new[ACC_W-1];
                        nim_mag_next = acc_mag;
                    end
                    default: ;
                endcase
            end
            S_DRE_WAIT, S_DIM_WAIT, S_SQ_WAIT:
            begin
                if (ds_done)
                begin
                    sat_next = sat_reg || sv_ds.sat;
                    if (state_reg == S_DIM_WAIT)
                        ri_next = sv_ds.val;
                    else
                        rr_next = sv_ds.val;
                    if (state_reg == S_SQ_WAIT)
                        ri_next = '0;
                end
            end
            S_STEP_END:
            begin
                xr_next   = rr_reg;
                xi_next   = ri_reg;
                ecnt_next = ecnt_reg - ECNT_W'(1);
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ore_next = rr_reg;
                    oim_next = ri_reg;
                    ost_next = dz_reg ? ST_DIV0 : (sat_reg ? ST_SAT : ST_OK);
                    mv_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        kind_reg    <= kind_next;
        xr_reg      <= xr_next;
        xi_reg      <= xi_next;
        br_reg      <= br_next;
        bi_reg      <= bi_next;
        ecnt_reg    <= ecnt_next;
        pidx_reg    <= pidx_next;
        acc_reg     <= acc_next;
        prod_reg    <= mul_a * mul_b;
        den_reg     <= den_next;
        nre_neg_reg <= nre_neg_next;
        nre_mag_reg <= nre_mag_next;
        nim_neg_reg <= nim_neg_next;
        nim_mag_reg <= nim_mag_next;
        rr_reg      <= rr_next;
        ri_reg      <= ri_next;
        sat_reg     <= sat_next;
        dz_reg      <= dz_next;
        ore_reg     <= ore_next;
        oim_reg     <= oim_next;
        ost_reg     <= ost_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(OUT_W - 2*DATA_W - 2){1'b0}}, ost_reg, oim_reg, ore_reg};

    // Checks
    a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && dz_reg) |-> (op_reg == OP_DIV))
        else $error("divide-by-zero flag on a non-divide");
    a_dz_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[65:64] == ST_DIV0) |-> (m_tdata[63:0] == '0))
        else $error("divide-by-zero result not zero");
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        ds_done |-> (state_reg == S_DRE_WAIT || state_reg == S_DIM_WAIT ||
                     state_reg == S_SQ_WAIT))
        else $error("divider finished outside a wait state");
    a_acc_after_prod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> ($past(state_reg) == S_PROD))
        else $error("accumulate without a product");

endmodule
